>>> rtl/pelco_d_frame_receiver_macros.svh
// assertion macros for the pelco-d frame receiver
`ifndef PELCO_D_FRAME_RECEIVER_MACROS_SVH
`define PELCO_D_FRAME_RECEIVER_MACROS_SVH

// check sampled on clk, off while reset is asserted
`define PDFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define PDFR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pdfr_pkg.sv
`default_nettype none

package pdfr_pkg;

    // frame layout
    localparam logic [7:0] START_BYTE  = 8'hFF;
    localparam int         PAYLOAD_LEN = 5;
    localparam logic [2:0] CNT_IDLE    = 3'd0;
    localparam logic [2:0] CNT_SYNC    = 3'd1;
    localparam logic [2:0] CNT_LAST    = 3'd6;

    // gap timeout register
    localparam int          GAP_W     = 20;
    localparam logic [19:0] GAP_RESET = 20'd10000;

    // one received byte with its arrival time
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } in_item_t;

    // one assembled frame
    typedef struct packed {
        logic       frame_ok;
        logic [7:0] address;
        logic [7:0] command_one;
        logic [7:0] command_two;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [7:0] received_checksum;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/pdfr_in_stage.sv
`default_nettype none

module pdfr_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pdfr_pkg::in_item_t in_item,
    input  wire logic              advance,
    output logic                   s1_valid,
    output pdfr_pkg::in_item_t     s1_item
);

    logic               valid_reg;
    logic               valid_next;
    pdfr_pkg::in_item_t item_reg;

    // the stage frees up whenever its transaction moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

>>> rtl/pdfr_assembler.sv
`default_nettype none

module pdfr_assembler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [19:0]        cfg_wdata,
    input  wire logic               s1_valid,
    input  wire pdfr_pkg::in_item_t s1_item,
    input  wire logic               advance,
    output logic                    last_byte,
    output logic                    res_valid,
    output pdfr_pkg::result_t       res
);

    logic [19:0] gap_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [31:0] last_time_reg;
    logic [7:0]  payload_reg [pdfr_pkg::PAYLOAD_LEN];

    logic [31:0] elapsed;
    logic        timed_out;
    logic [2:0]  eff_count;
    logic [7:0]  eff_sum;
    logic [2:0]  wr_idx;
    logic        wr_en;
    logic [7:0]  b;

    assign b = s1_item.rx_byte;

    // gap check against the previous arrival
    assign elapsed   = s1_item.time_us - last_time_reg;
    assign timed_out = (count_reg != pdfr_pkg::CNT_IDLE) && (elapsed > {12'd0, gap_reg});
    assign eff_count = timed_out ? pdfr_pkg::CNT_IDLE : count_reg;
    assign eff_sum   = timed_out ? 8'd0 : sum_reg;

    // counts of six and the unused seven both close the frame
    assign last_byte = s1_valid && (eff_count >= pdfr_pkg::CNT_LAST);
    assign wr_idx    = eff_count - 3'd1;
    assign wr_en     = advance && (eff_count != pdfr_pkg::CNT_IDLE) && !last_byte;

    // next count and running sum
    always_comb
    begin
        count_next = eff_count;
        sum_next   = eff_sum;
        priority if (eff_count == pdfr_pkg::CNT_IDLE)
        begin
            if (b == pdfr_pkg::START_BYTE)
            begin
                count_next = pdfr_pkg::CNT_SYNC;
                sum_next   = 8'd0;
            end
        end
        else if (eff_count < pdfr_pkg::CNT_LAST)
        begin
            count_next = eff_count + 3'd1;
            sum_next   = eff_sum + b;
        end
        else
        begin
            count_next = pdfr_pkg::CNT_IDLE;
            sum_next   = 8'd0;
        end
    end

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= pdfr_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            gap_reg <= cfg_wdata;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= pdfr_pkg::CNT_IDLE;
            sum_reg       <= 8'd0;
            last_time_reg <= 32'd0;
        end
        else if (advance)
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            last_time_reg <= s1_item.time_us;
        end
    end

    // payload bytes, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            payload_reg[wr_idx] <= b;
        end
    end

    // result of the closing byte
    assign res_valid             = advance && last_byte;
    assign res.frame_ok          = (eff_sum == b);
    assign res.address           = payload_reg[0];
    assign res.command_one       = payload_reg[1];
    assign res.command_two       = payload_reg[2];
    assign res.data_one          = payload_reg[3];
    assign res.data_two          = payload_reg[4];
    assign res.received_checksum = b;

endmodule

`default_nettype wire

>>> rtl/pdfr_out_stage.sv
`default_nettype none

module pdfr_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire pdfr_pkg::result_t res,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pdfr_pkg::result_t      out_res
);

    logic              valid_reg;
    logic              valid_next;
    pdfr_pkg::result_t res_reg;

    // room when empty or when the held transaction leaves now
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

>>> rtl/pelco_d_frame_receiver.sv
// a closing byte passes the input register, its result the output register
// throughput: one byte per cycle through the input register and the frame
//   update logic; a seventh byte waits only while the output register holds
//   a frame that has not been taken
// reset: async active low, clears the frame count, sum, last arrival time and
//   valid flags, loads the gap timeout with 10000; payload bytes are not reset
`default_nettype none

module pelco_d_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] time_us,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             frame_ok,
    output logic [7:0]       address,
    output logic [7:0]       command_one,
    output logic [7:0]       command_two,
    output logic [7:0]       data_one,
    output logic [7:0]       data_two,
    output logic [7:0]       received_checksum
);

    pdfr_pkg::in_item_t in_item;
    pdfr_pkg::in_item_t s1_item;
    pdfr_pkg::result_t  res;
    pdfr_pkg::result_t  out_res;
    logic               s1_valid;
    logic               advance;
    logic               last_byte;
    logic               res_valid;
    logic               can_load;

    assign in_item.rx_byte = rx_byte;
    assign in_item.time_us = time_us;

    // a byte moves on unless it closes a frame and the output is full
    assign advance = s1_valid && (!last_byte || can_load);

    pdfr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    pdfr_assembler u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .advance   (advance),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    pdfr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // result fields
    assign frame_ok          = out_res.frame_ok;
    assign address           = out_res.address;
    assign command_one       = out_res.command_one;
    assign command_two       = out_res.command_two;
    assign data_one          = out_res.data_one;
    assign data_two          = out_res.data_two;
    assign received_checksum = out_res.received_checksum;

endmodule

`default_nettype wire

>>> rtl/pdfr_checker.sv
`default_nettype none
`include "pelco_d_frame_receiver_macros.svh"

module pdfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        frame_ok,
    input wire logic [7:0]  address,
    input wire logic [7:0]  command_one,
    input wire logic [7:0]  command_two,
    input wire logic [7:0]  data_one,
    input wire logic [7:0]  data_two,
    input wire logic [7:0]  received_checksum
);

    logic [7:0]  frame_sum;
    logic        sum_match;
    logic        out_stall;
    logic [48:0] out_fields;

    // 8-bit sum of the five payload bytes
    assign frame_sum = 8'(address + command_one + command_two + data_one + data_two);
    assign sum_match = (frame_sum == received_checksum);

    // result held back by the receiver, and all of its fields
    assign out_stall  = out_valid && !out_ready;
    assign out_fields = {frame_ok, address, command_one, command_two, data_one, data_two,
                         received_checksum};

    // no result is shown while reset is applied
    `PDFR_ASSERT_RST(a_rst_no_out, !rst_n && $past(!rst_n) |-> !out_valid, "valid in reset")

    // a stalled result holds its fields
    `PDFR_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_fields), "held result changed")

    // the flag agrees with the delivered bytes
    `PDFR_ASSERT(a_flag_sum, out_valid |-> (frame_ok == sum_match), "flag disagrees with sum")

    // input is never held off while the output register is empty
    `PDFR_ASSERT(a_ready_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind pelco_d_frame_receiver pdfr_checker u_pdfr_checker (.*);

`default_nettype wire
